// ----- design/palette_index_unpacker_unit_defines.svh -----
// ----------------------------------------------------------------------------
// palette index unpacker assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef PALETTE_INDEX_UNPACKER_UNIT_DEFINES_SVH
`define PALETTE_INDEX_UNPACKER_UNIT_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define PIU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("palette index unpacker: property violated");
// condition must never be seen at a clock edge out of reset
`define PIU_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("palette index unpacker: forbidden condition seen");
`else
`define PIU_ASSERT(lbl, prop)
`define PIU_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- design/piu_pkg.sv -----
// ----------------------------------------------------------------------------
// piu_pkg
// shared types, constants and width helpers of the palette index unpacker
// ----------------------------------------------------------------------------
package piu_pkg;

  localparam int WordBits = 64;
  localparam int PsW      = 13;
  localparam int FloorW   = 5;
  localparam int CntW     = 13;
  localparam int IdxW     = 16;
  localparam int SlotW    = 7;
  localparam int WidthW   = 5;
  localparam int ValW     = 31;
  localparam int CfgAddrW = 2;
  localparam int UserW    = 5;

  // register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] CfgPaletteSize = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgFloorBits   = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgEntryCount  = 2'd2;

  typedef enum logic [1:0] {
    LenOk     = 2'd0,
    LenBeyond = 2'd1,
    LenShort  = 2'd2
  } len_err_e;

  typedef struct packed {
    logic [PsW-1:0]    palette_size;
    logic [FloorW-1:0] floor_bits;
    logic [CntW-1:0]   entry_count;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic can_emit;
    logic word_end;
  } dp_sts_t;

  // bits per slot: enough to cover the palette, at least one, raised to the floor
  function automatic logic [WidthW-1:0] entry_width(logic [PsW-1:0] ps,
                                                    logic [FloorW-1:0] fl);
    logic [PsW-1:0]    m;
    logic [WidthW-1:0] w;
    m = ps - PsW'(1);
    w = WidthW'(1);
    if (ps > PsW'(1)) begin
      for (int i = 0; i < PsW; i++) begin
        if (m[i]) w = WidthW'(i + 1);
      end
    end
    if (fl > w) w = fl;
    return w;
  endfunction

  // slots per 64-bit word for a given slot width
  function automatic logic [SlotW-1:0] slots_per_word(logic [WidthW-1:0] w);
    logic [SlotW-1:0] n;
    case (w) inside
      5'd1:       n = 7'd64;
      5'd2:       n = 7'd32;
      5'd3:       n = 7'd21;
      5'd4:       n = 7'd16;
      5'd5:       n = 7'd12;
      5'd6:       n = 7'd10;
      5'd7:       n = 7'd9;
      5'd8:       n = 7'd8;
      5'd9:       n = 7'd7;
      5'd10:      n = 7'd6;
      [5'd11:5'd12]: n = 7'd5;
      [5'd13:5'd16]: n = 7'd4;
      [5'd17:5'd21]: n = 7'd3;
      [5'd22:5'd31]: n = 7'd2;
      default:    n = 7'd64;
    endcase
    return n;
  endfunction

endpackage

// ----- design/piu_cfg.sv -----
// ----------------------------------------------------------------------------
// piu_cfg
// configuration registers with saturation on write
// ----------------------------------------------------------------------------
module piu_cfg #(
  parameter int MAX_ENTRIES = 4096,
  parameter int MAX_PALETTE = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [piu_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [piu_pkg::CntW-1:0]      cfg_wdata_i,
  output piu_pkg::cfg_t                 cfg_o
);
  import piu_pkg::*;

  localparam int EntryRst = (MAX_ENTRIES < 4096) ? MAX_ENTRIES : 4096;

  cfg_t              cfg_q;
  logic [31:0]       wdata_wide;
  logic [PsW-1:0]    ps_sat;
  logic [CntW-1:0]   ec_sat;

  assign wdata_wide = 32'(cfg_wdata_i);
  assign ps_sat = (wdata_wide > 32'(MAX_PALETTE)) ? PsW'(MAX_PALETTE) : PsW'(cfg_wdata_i);
  assign ec_sat = (wdata_wide > 32'(MAX_ENTRIES)) ? CntW'(MAX_ENTRIES) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.palette_size <= PsW'(16);
      cfg_q.floor_bits   <= FloorW'(4);
      cfg_q.entry_count  <= CntW'(EntryRst);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgPaletteSize: cfg_q.palette_size <= ps_sat;
        CfgFloorBits:   cfg_q.floor_bits   <= cfg_wdata_i[FloorW-1:0];
        CfgEntryCount:  cfg_q.entry_count  <= ec_sat;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/piu_ctrl.sv -----
// ----------------------------------------------------------------------------
// piu_ctrl
// word sequencer: takes one word, steps its slots, then frees the input
// ----------------------------------------------------------------------------
module piu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  piu_pkg::dp_sts_t  sts_i,
  output piu_pkg::dp_cmd_t  cmd_o
);
  import piu_pkg::*;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (s_tvalid_i) begin
            state_q <= StRun;
            ready_q <= 1'b0;
          end
        end
        StRun: begin
          if (sts_i.can_emit && sts_i.word_end) begin
            state_q <= StIdle;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign s_tready_o = ready_q;
  assign cmd_o.load = s_tvalid_i && ready_q;
  assign cmd_o.step = (state_q == StRun) && sts_i.can_emit;

endmodule

// ----- design/piu_dp.sv -----
// ----------------------------------------------------------------------------
// piu_dp
// slot extractor, entry counter and output register
// ----------------------------------------------------------------------------
module piu_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  piu_pkg::cfg_t                 cfg_i,
  input  piu_pkg::dp_cmd_t              cmd_i,
  output piu_pkg::dp_sts_t              sts_o,
  input  logic [piu_pkg::WordBits-1:0]  word_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [piu_pkg::IdxW-1:0]      out_idx_o,
  output logic                          out_last_o,
  output logic [piu_pkg::UserW-1:0]     out_user_o
);
  import piu_pkg::*;

  // word in flight
  logic [WordBits-1:0] word_q;
  logic                last_q;
  logic                beyond_q;
  logic                cerr_q;
  logic [WidthW-1:0]   w_q;
  logic [SlotW-1:0]    per_q;
  logic [SlotW-1:0]    slot_q;
  logic [CntW-1:0]     emitted_q;

  // output register
  logic                out_valid_q;
  logic [IdxW-1:0]     out_idx_q;
  logic                out_last_q;
  logic                out_done_q;
  logic                out_ierr_q;
  len_err_e            out_lerr_q;
  logic                out_cerr_q;

  logic [31:0]         mask_wide;
  logic [ValW-1:0]     slot_val;
  logic [CntW-1:0]     emitted_nx;
  logic                slot_ierr;
  logic                slot_done;
  logic                slot_last;

  assign mask_wide  = (32'd1 << w_q) - 32'd1;
  assign slot_val   = word_q[ValW-1:0] & mask_wide[ValW-1:0];
  assign emitted_nx = emitted_q + CntW'(1);
  assign slot_ierr  = slot_val >= ValW'(cfg_i.palette_size);
  assign slot_done  = emitted_nx == cfg_i.entry_count;
  assign slot_last  = ((slot_q + SlotW'(1)) == per_q) || slot_done;

  assign sts_o.can_emit = !out_valid_q || out_ready_i;
  assign sts_o.word_end = beyond_q || slot_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
        if (beyond_q) begin
          if (last_q) emitted_q <= '0;
        end else begin
          emitted_q <= (slot_last && last_q) ? '0 : emitted_nx;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q   <= word_i;
      last_q   <= last_i;
      beyond_q <= emitted_q >= cfg_i.entry_count;
      cerr_q   <= cfg_i.palette_size == '0;
      w_q      <= entry_width(cfg_i.palette_size, cfg_i.floor_bits);
      per_q    <= slots_per_word(entry_width(cfg_i.palette_size, cfg_i.floor_bits));
      slot_q   <= '0;
    end else if (cmd_i.step) begin
      word_q <= word_q >> w_q;
      slot_q <= slot_q + SlotW'(1);
    end
    if (cmd_i.step) begin
      out_cerr_q <= cerr_q;
      if (beyond_q) begin
        out_idx_q  <= '0;
        out_last_q <= 1'b1;
        out_done_q <= 1'b0;
        out_ierr_q <= 1'b0;
        out_lerr_q <= LenBeyond;
      end else begin
        out_idx_q  <= slot_val[IdxW-1:0];
        out_last_q <= slot_last;
        out_done_q <= slot_done;
        out_ierr_q <= slot_ierr;
        out_lerr_q <= (slot_last && last_q && !slot_done) ? LenShort : LenOk;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_idx_o   = out_idx_q;
  assign out_last_o  = out_last_q;
  assign out_user_o  = {out_cerr_q, out_lerr_q, out_ierr_q, out_done_q};

endmodule

// ----- design/palette_index_unpacker_unit.sv -----
// the first index of a word is stepped from the run state into the output register
// the single slot extractor steps one slot per cycle while the output register can take a result;
// a word past the count gives one result
// the input is free again once the word's last result sits in the output register
// reset (rst_ni, asynchronous, active low) restores palette_size 16, floor_bits 4,
// entry_count 4096 (or MAX_ENTRIES if smaller), clears the entry count and the output
`include "palette_index_unpacker_unit_defines.svh"
// ----------------------------------------------------------------------------
// palette_index_unpacker_unit
// unpacks 64-bit words of fixed-width palette indices, low slot first
// ----------------------------------------------------------------------------
module palette_index_unpacker_unit #(
  parameter int MAX_ENTRIES = 4096,
  parameter int MAX_PALETTE = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [piu_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [piu_pkg::CntW-1:0]      cfg_wdata_i,
  // word requests
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [piu_pkg::WordBits-1:0]  s_axis_tdata_i,  // packed_word
  input  logic                          s_axis_tlast_i,  // last_word
  // index requests
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [piu_pkg::IdxW-1:0]      m_axis_tdata_o,  // palette_index
  output logic                          m_axis_tlast_o,  // run_last
  // entries_done, index_error, length_error[1:0], config_error
  output logic [piu_pkg::UserW-1:0]     m_axis_tuser_o
);
  import piu_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // register file, saturating palette size and entry count on write
  piu_cfg #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_PALETTE (MAX_PALETTE)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequencer: idle takes a word, run steps until the word's last result
  piu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // word shifter, slot mask and compare, running entry count, output register
  piu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .word_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_idx_o   (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_user_o  (m_axis_tuser_o)
  );

  // a taken word closes the input in the following cycle
  `PIU_ASSERT(a_busy_after_take, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
  // a word past the count gives a bare closing result
  `PIU_ASSERT(a_beyond_bare, (m_axis_tvalid_o && m_axis_tuser_o[3:2] == LenBeyond) |-> (m_axis_tdata_o == '0 && !m_axis_tuser_o[0] && !m_axis_tuser_o[1] && m_axis_tlast_o))
  // completing the count always closes the word
  `PIU_ASSERT(a_done_closes, (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> m_axis_tlast_o)
  // unused length code never appears
  `PIU_ASSERT_NEVER(a_no_len_code3, m_axis_tvalid_o && m_axis_tuser_o[3:2] == 2'd3)

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for palette_index_unpacker_unit: packed 64-bit words go
// in on the slave stream, every unpacked index is predicted in the bench and
// compared field by field with the master stream, under random stalls on
// both sides and through register settings that span the full field ranges
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import piu_pkg::*;

  localparam int PaletteCap  = 4096;
  localparam int EntryCap    = 4096;
  localparam int RandomWords = 235;
  localparam int LongHold    = 300;   // receiver hold-off that backs up the input
  localparam int DrainCycles = 4;     // output register plus margin

  // register index with no register behind it
  localparam logic [CfgAddrW-1:0] CfgSpare = 2'd3;

  // one word request as offered on the slave side
  typedef struct packed {
    logic [WordBits-1:0] word;
    logic                last_word;
  } word_req_t;

  // one index request as seen on the master side
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            run_last;
    logic            done;
    logic            ierr;
    len_err_e        lerr;
    logic            cerr;
  } index_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // register write port
  logic                cfg_we    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = CfgPaletteSize;
  logic [CntW-1:0]     cfg_wdata = '0;

  // word stream into the block
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [WordBits-1:0] s_data  = '0;   // packed_word
  logic                s_last  = 1'b0; // last_word

  // index stream out of the block
  logic            m_valid;
  logic            m_ready = 1'b0;
  logic [IdxW-1:0] m_data;   // palette_index
  logic            m_last;   // run_last
  logic [UserW-1:0] m_user;  // entries_done, index_error, length_error[1:0], config_error

  palette_index_unpacker_unit #(
    .MAX_ENTRIES(EntryCap),
    .MAX_PALETTE(PaletteCap)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last),
    .m_axis_tuser_o (m_user)
  );

  // words waiting for the driver and indices waiting for the block
  word_req_t  pending_words[$];
  index_rsp_t expected_indices[$];

  // shadow of the registers and of the running entry count
  int unsigned pal_size   = 16;
  int unsigned floor_bits = 4;
  int unsigned ent_count  = EntryCap;
  int unsigned emitted    = 0;

  // traffic controls shared by the stimulus and the stream processes
  logic idle_en       = 1'b1;
  logic long_hold_req = 1'b0;
  int   tx_gap        = 0;
  int   rx_gap        = 0;
  int   hold_left     = 0;
  logic hold_taken    = 1'b0;

  // bookkeeping
  int words_queued    = 0;
  int words_taken     = 0;
  int indices_checked = 0;
  int fault_count     = 0;
  int ierr_seen       = 0;
  int overrun_words   = 0;
  int short_words     = 0;
  int cfg_err_words   = 0;
  int reg_writes      = 0;

  word_req_t  next_req;
  index_rsp_t got;
  index_rsp_t want;

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // bits per slot: cover the palette with at least one bit, then apply the floor
  function automatic int unsigned slot_bits();
    int unsigned w;
    w = 1;
    while (w < 31 && (32'd1 << w) < pal_size) w++;
    if (floor_bits > w) w = floor_bits;
    return w;
  endfunction

  // append one expectation at the tail of the queue
  function automatic void add_expected(input index_rsp_t r);
    expected_indices.insert(expected_indices.size(), r);
  endfunction

  // expected index requests for one accepted word
  function automatic void unpack_word(input logic [WordBits-1:0] word,
                                      input logic last_word);
    index_rsp_t  r;
    int unsigned w;
    int unsigned n_out;
    logic [63:0] lane;
    logic [63:0] v;
    logic        cut_short;
    w         = slot_bits();
    lane      = (64'd1 << w) - 64'd1;
    r         = '0;
    r.cerr    = (pal_size == 0);
    cfg_err_words += int'(pal_size == 0);
    // container already complete: a single overrun marker
    if (emitted >= ent_count) begin
      r.run_last = 1'b1;
      r.lerr     = LenBeyond;
      add_expected(r);
      overrun_words++;
      if (last_word) emitted = 0;
      return;
    end
    n_out = 64 / w;
    if (n_out > ent_count - emitted) n_out = ent_count - emitted;
    // stream closed before the count was reached
    cut_short = last_word && (emitted + n_out < ent_count);
    short_words += int'(cut_short);
    for (int s = 0; s < n_out; s++) begin
      v = (word >> (s * w)) & lane;
      emitted++;
      r.idx      = v[IdxW-1:0];
      r.ierr     = (v >= 64'(pal_size));
      r.done     = (emitted == ent_count);
      r.run_last = (s == n_out - 1);
      r.lerr     = (cut_short && s == n_out - 1) ? LenShort : LenOk;
      ierr_seen += int'(r.ierr);
      add_expected(r);
    end
    if (last_word) emitted = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // word driver: one request at a time, random gaps while idling is on
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_last  <= 1'b0;
      tx_gap  <= 0;
    end else begin
      if (s_valid && s_ready) begin
        unpack_word(s_data, s_last);
        words_taken++;
      end
      if (!s_valid || s_ready) begin
        if (tx_gap > 0) begin
          tx_gap  <= tx_gap - 1;
          s_valid <= 1'b0;
        end else if (idle_en && pending_words.size() != 0 && $urandom_range(0, 5) == 0) begin
          // random gap before the next word
          tx_gap  <= $urandom_range(0, 4);
          s_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_req = pending_words.pop_front();
          s_valid <= 1'b1;
          s_data  <= next_req.word;
          s_last  <= next_req.last_word;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // index receiver: random stall bursts plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      rx_gap     <= 0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (long_hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= LongHold - 1;
      m_ready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap  <= rx_gap - 1;
      m_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rx_gap  <= $urandom_range(0, 4);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checker: each accepted index against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void report_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("tb: %s", what);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      got.idx      = m_data;
      got.run_last = m_last;
      got.done     = m_user[0];
      got.ierr     = m_user[1];
      got.lerr     = len_err_e'(m_user[3:2]);
      got.cerr     = m_user[4];
      indices_checked++;
      if (expected_indices.size() == 0) begin
        report_fault($sformatf("index %h at %0t with nothing expected", got.idx, $realtime));
      end else begin
        want = expected_indices.pop_front();
        if (got.idx != want.idx || got.run_last != want.run_last || got.done != want.done ||
            got.ierr != want.ierr || got.lerr != want.lerr || got.cerr != want.cerr)
          report_fault($sformatf(
            "mismatch at %0t idx/last/done/ierr/len/cfg want %h %b %b %b %0d %b got %h %b %b %b %0d %b",
            $realtime, want.idx, want.run_last, want.done, want.ierr, want.lerr, want.cerr,
            got.idx, got.run_last, got.done, got.ierr, got.lerr, got.cerr));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // register write, shadow follows the saturation rules of the block
  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input int unsigned value);
    int unsigned v;
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value[CntW-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    reg_writes++;
    v = value & 32'h1FFF;
    case (addr)
      CfgPaletteSize: pal_size   = (v > PaletteCap) ? PaletteCap : v;
      CfgFloorBits:   floor_bits = value & 32'h1F;
      CfgEntryCount:  ent_count  = (v > EntryCap) ? EntryCap : v;
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned ps, input int unsigned fl, input int unsigned cnt);
    write_reg(CfgPaletteSize, ps);
    write_reg(CfgFloorBits, fl);
    write_reg(CfgEntryCount, cnt);
  endtask

  task automatic queue_word(input logic [WordBits-1:0] word, input logic last_word);
    word_req_t r;
    r.word      = word;
    r.last_word = last_word;
    pending_words.insert(pending_words.size(), r);
    words_queued++;
  endtask

  // wait until every word is taken and every index has come back
  task automatic settle();
    while (words_taken != words_queued || expected_indices.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // random word, mostly with every slot inside the palette
  function automatic logic [WordBits-1:0] make_word();
    logic [63:0] word;
    logic [63:0] lane;
    int unsigned w;
    word = {$urandom, $urandom};
    if (pal_size != 0 && $urandom_range(0, 3) != 0) begin
      w    = slot_bits();
      lane = (64'd1 << w) - 64'd1;
      for (int s = 0; s < 64 / w; s++)
        word = (word & ~(lane << (s * w))) |
               (64'($urandom_range(0, pal_size - 1)) << (s * w));
    end
    return word;
  endfunction

  // random register set, weighted toward small palettes and counts
  task automatic random_regs();
    int unsigned ps;
    int unsigned fl;
    int unsigned cnt;
    case ($urandom_range(0, 9))
      0:       ps = 0;
      1:       ps = $urandom_range(PaletteCap + 1, 8191);
      2:       ps = $urandom_range(1, PaletteCap);
      default: ps = $urandom_range(1, 40);
    endcase
    fl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
    case ($urandom_range(0, 19))
      0:       cnt = 0;
      1:       cnt = $urandom_range(EntryCap - 64, 8191);
      default: cnt = $urandom_range(1, 120);
    endcase
    set_regs(ps, fl, cnt);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned per;
    int unsigned needed;
    int unsigned n_words;
    int unsigned n_cont;
    int          random_words;
    logic        open_end;

    random_words = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: four-bit slots, container ends far short of the count
    queue_word('0, 1'b0);
    queue_word('1, 1'b0);
    queue_word(64'hA5A5_5A5A_0F0F_F0F0, 1'b1);
    settle();

    // three-bit slots with one padding bit, count of ten: full slots flag,
    // then overrun words, one of them closing the container
    set_regs(5, 1, 10);
    queue_word('1, 1'b0);
    queue_word(make_word(), 1'b0);
    queue_word(make_word(), 1'b1);
    queue_word(64'h0123_4567_89AB_CDEF, 1'b1);
    settle();

    // empty palette and zero floor: one-bit slots, 64 results per word,
    // count saturated, unused register index written
    set_regs(0, 0, 8191);
    write_reg(CfgSpare, 8191);
    queue_word(make_word(), 1'b0);
    queue_word('0, 1'b1);
    settle();

    // saturated palette under the widest floor: two 31-bit slots per word
    set_regs(8191, 31, 5);
    queue_word('1, 1'b0);
    queue_word('0, 1'b0);
    queue_word(make_word(), 1'b1);
    settle();

    // 16-bit and 17-bit slots, palette at its cap
    set_regs(PaletteCap, 16, EntryCap);
    queue_word(64'hFFFF_1000_0FFF_0000, 1'b1);
    settle();
    write_reg(CfgFloorBits, 17);
    queue_word('1, 1'b1);
    settle();

    // zero count: every word overruns
    set_regs(2, 1, 0);
    queue_word(make_word(), 1'b0);
    queue_word(make_word(), 1'b1);
    settle();

    // single-entry palette, count of three, then an overrun that closes
    set_regs(1, 0, 3);
    queue_word(64'h5, 1'b0);
    queue_word('1, 1'b1);
    settle();
    set_regs(3, 0, 100);
    queue_word(make_word(), 1'b1);
    settle();

    // settings change in the middle of a container; floor write with
    // upper data bits set
    set_regs(PaletteCap + 1, 13'h1FE2, 70);
    queue_word(make_word(), 1'b0);
    settle();
    set_regs(2, 0, 70);
    queue_word('1, 1'b1);
    settle();

    // receiver holds off while the sender keeps offering words
    set_regs(16, 4, 64);
    for (int k = 0; k < 8; k++) queue_word(make_word(), k % 4 == 3);
    random_words += 8;
    long_hold_req <= 1'b1;
    settle();

    // random register sets, each with a few containers of random content
    while (random_words < RandomWords) begin
      if (random_words >= RandomWords - 40) idle_en = 1'b0;
      random_regs();
      per    = 64 / slot_bits();
      n_cont = $urandom_range(1, 3);
      for (int c = 0; c < n_cont; c++) begin
        needed = (ent_count + per - 1) / per;
        case ($urandom_range(0, 6))
          0:       n_words = (needed > 1) ? needed - 1 : 1;   // ends short
          1:       n_words = needed + $urandom_range(1, 2);   // overruns
          default: n_words = needed;
        endcase
        if (n_words == 0) n_words = 1;
        if (n_words > 24) n_words = 24;
        // sometimes leave the container open across the next register set
        open_end = (c == n_cont - 1) && ($urandom_range(0, 4) == 0);
        for (int k = 0; k < n_words; k++)
          queue_word(make_word(), (k == n_words - 1) && !open_end);
        random_words += n_words;
      end
      settle();
    end

    settle();
    if (expected_indices.size() != 0) report_fault("indices still expected at the end");
    $display("summary: %0d words, %0d indices checked, %0d register writes",
             words_taken, indices_checked, reg_writes);
    $display("summary: %0d out-of-palette, %0d overrun words, %0d short ends, %0d empty-palette words",
             ierr_seen, overrun_words, short_words, cfg_err_words);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- palette_index_unpacker_unit.f -----
+incdir+design
design/piu_pkg.sv
design/piu_cfg.sv
design/piu_ctrl.sv
design/piu_dp.sv
design/palette_index_unpacker_unit.sv
test/tb.sv
